>>> hw/rtl/resp_request_parser_top_macros.svh
// assertion helpers for the request parser
// checks are sampled on clk and held off while arst_n is low
`ifndef RESP_REQUEST_PARSER_TOP_MACROS_SVH
`define RESP_REQUEST_PARSER_TOP_MACROS_SVH

`ifndef SYNTH
`define RRP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("request parser check failed");
`define RRP_NEVER(lbl, cond) \
	`RRP_ASSERT(lbl, !(cond))
`else
`define RRP_ASSERT(lbl, prop)
`define RRP_NEVER(lbl, cond)
`endif

`endif

>>> hw/rtl/rrp_pkg.sv
`timescale 1ns / 1ps

package rrp_pkg;

	localparam int LENGTH_BITS_DEF = 30;
	localparam int COUNT_BITS_DEF  = 21;

	// widths of the limit registers
	localparam int BULK_REG_W = 30;
	localparam int CNT_REG_W  = 21;
	localparam int CFG_IDX_W  = 1;

	localparam logic [BULK_REG_W-1:0] MAX_BULK_RESET = 30'd536870912;
	localparam logic [CNT_REG_W-1:0]  MAX_ARG_RESET  = 21'd1048576;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_BULK = 1'b0,
		REG_MAX_ARG  = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		REQ_BYTE    = 1'b0,
		REQ_RESTART = 1'b1
	} req_t;

	typedef enum logic [2:0] {
		K_ARG_BYTE = 3'd0,
		K_ARG_END  = 3'd1,
		K_CMD_END  = 3'd2,
		K_NULL_ARR = 3'd3,
		K_ERROR    = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		E_BAD_COUNT  = 3'd0,
		E_BAD_LENGTH = 3'd1,
		E_BAD_TERM   = 3'd2,
		E_BAD_NUMBER = 3'd3,
		E_NO_HEADER  = 3'd4,
		E_OVER_LIMIT = 3'd5
	} err_t;

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		err_t       code;
		logic       last;
	} res_t;

	// results of one processed beat, handed to the output buffer
	typedef struct packed {
		logic       valid;
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

>>> hw/rtl/rrp_parse_core.sv
`timescale 1ns / 1ps

module rrp_parse_core import rrp_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic                  req_type,
	input  logic [7:0]            data_byte,
	input  logic [BULK_REG_W-1:0] max_bulk_length,
	input  logic [CNT_REG_W-1:0]  max_arg_count,
	output push_t                 push
);

	localparam int CW0 = (LENGTH_BITS > COUNT_BITS) ? LENGTH_BITS : COUNT_BITS;
	localparam int CW1 = (CW0 > BULK_REG_W) ? CW0 : BULK_REG_W;
	localparam int CW  = ((CW1 > CNT_REG_W) ? CW1 : CNT_REG_W) + 1;

	localparam logic [LENGTH_BITS-1:0] LEN_MASK   = {LENGTH_BITS{1'b1}};
	localparam logic [CW-1:0]          LEN_MASK_W = CW'(LEN_MASK);
	localparam logic [CW-1:0]          CNT_MASK_W = CW'({COUNT_BITS{1'b1}});

	typedef enum logic [7:0] {
		M_START   = 8'b0000_0001,
		M_COUNT   = 8'b0000_0010,
		M_HEADER  = 8'b0000_0100,
		M_LENGTH  = 8'b0000_1000,
		M_PAYLOAD = 8'b0001_0000,
		M_PAY_CR  = 8'b0010_0000,
		M_PAY_LF  = 8'b0100_0000,
		M_INLINE  = 8'b1000_0000
	} mode_t;

	typedef enum logic [3:0] {
		PH_LEAD   = 4'b0001,
		PH_SIGN   = 4'b0010,
		PH_DIGITS = 4'b0100,
		PH_CR     = 4'b1000
	} phase_t;

	function automatic res_t mk(kind_t k, logic [7:0] d, err_t e);
		res_t r;
		r.kind = k;
		r.data = d;
		r.code = e;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic logic is_space(logic [7:0] b);
		return b inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
	endfunction

	mode_t                  mode_q, mode_d;
	phase_t                 phase_q, phase_d;
	logic [LENGTH_BITS-1:0] value_q, value_d;
	logic [LENGTH_BITS-1:0] bulk_q, bulk_d;
	logic [COUNT_BITS-1:0]  args_q, args_d;
	logic                   neg_q, neg_d;
	logic                   tok_q, tok_d;
	logic                   lht_q, lht_d;
	logic                   err_q, err_d;
	logic                   ls_q, ls_d;
	logic                   lcr_q, lcr_d;

	logic [LENGTH_BITS+3:0] prod;
	logic [LENGTH_BITS-1:0] value_sat;
	logic [CW-1:0]          mag_w;
	logic [CW-1:0]          mbl_w;
	logic [CW-1:0]          mac_w;

	res_t       rv [2];
	logic [1:0] n;
	logic       do_inline;
	logic       arg_done;
	logic       nf_cont;
	logic       nf_dig;
	logic       nf_done;
	logic       nf_bad;

	// accumulator step, saturating at the all-ones value
	assign prod = ({4'b0, value_q} << 3) + ({4'b0, value_q} << 1)
		+ (LENGTH_BITS + 4)'(data_byte[3:0]);
	assign value_sat = (prod > {4'b0, LEN_MASK}) ? LEN_MASK : prod[LENGTH_BITS-1:0];

	assign mag_w = CW'(value_q);
	assign mbl_w = CW'(max_bulk_length);
	assign mac_w = CW'(max_arg_count);

	always_comb begin
		mode_d    = mode_q;
		phase_d   = phase_q;
		value_d   = value_q;
		bulk_d    = bulk_q;
		args_d    = args_q;
		neg_d     = neg_q;
		tok_d     = tok_q;
		lht_d     = lht_q;
		err_d     = err_q;
		ls_d      = ls_q;
		lcr_d     = lcr_q;
		rv[0]     = mk(K_ARG_BYTE, 8'h00, E_BAD_COUNT);
		rv[1]     = mk(K_ARG_BYTE, 8'h00, E_BAD_COUNT);
		n         = 2'd0;
		do_inline = 1'b0;
		arg_done  = 1'b0;
		nf_cont   = 1'b1;
		nf_dig    = 1'b0;
		nf_done   = 1'b0;
		nf_bad    = 1'b0;

		if (req_type == REQ_RESTART) begin
			mode_d  = M_START;
			phase_d = PH_LEAD;
			value_d = '0;
			bulk_d  = '0;
			args_d  = '0;
			neg_d   = 1'b0;
			tok_d   = 1'b0;
			lht_d   = 1'b0;
			err_d   = 1'b0;
			ls_d    = 1'b0;
			lcr_d   = 1'b0;
		end else if (!err_q) begin
			case (mode_q)
				M_START: begin
					if (data_byte == CH_STAR) begin
						value_d = '0;
						neg_d   = 1'b0;
						phase_d = PH_LEAD;
						ls_d    = 1'b0;
						lcr_d   = 1'b0;
						mode_d  = M_COUNT;
					end else begin
						tok_d     = 1'b0;
						lht_d     = 1'b0;
						args_d    = '0;
						bulk_d    = '0;
						mode_d    = M_INLINE;
						do_inline = 1'b1;
					end
				end
				M_COUNT, M_LENGTH: begin
					// a CR seen in leading whitespace resolves on the next byte
					if (phase_q == PH_LEAD && lcr_q) begin
						lcr_d = 1'b0;
						if (data_byte == CH_LF) begin
							nf_cont = 1'b0;
							nf_bad  = ls_q;
							nf_done = !ls_q;
						end else begin
							ls_d = 1'b1;
						end
					end
					if (nf_cont) begin
						case (phase_q)
							PH_LEAD: begin
								if (data_byte == CH_CR) begin
									lcr_d = 1'b1;
								end else if (is_space(data_byte)) begin
									ls_d = 1'b1;
								end else begin
									ls_d = 1'b1;
									if (data_byte == CH_PLUS || data_byte == CH_MINUS) begin
										neg_d   = (data_byte == CH_MINUS);
										phase_d = PH_SIGN;
									end else begin
										nf_dig = 1'b1;
									end
								end
							end
							PH_SIGN: nf_dig = 1'b1;
							PH_DIGITS: begin
								if (data_byte == CH_CR)
									phase_d = PH_CR;
								else
									nf_dig = 1'b1;
							end
							default: begin
								nf_done = (data_byte == CH_LF);
								nf_bad  = (data_byte != CH_LF);
							end
						endcase
					end
					if (nf_dig) begin
						if (data_byte inside {[CH_ZERO:CH_NINE]}) begin
							value_d = value_sat;
							phase_d = PH_DIGITS;
						end else begin
							nf_bad = 1'b1;
						end
					end
					if (nf_bad) begin
						rv[n[0]] = mk(K_ERROR, 8'h00, E_BAD_NUMBER);
						n        = n + 2'd1;
						err_d    = 1'b1;
					end else if (nf_done && mode_q == M_COUNT) begin
						mode_d = M_START;
						if (neg_q && mag_w != '0) begin
							if (mag_w == CW'(1)) begin
								rv[n[0]] = mk(K_NULL_ARR, 8'h00, E_BAD_COUNT);
								n        = n + 2'd1;
							end else begin
								rv[n[0]] = mk(K_ERROR, 8'h00, E_BAD_COUNT);
								n        = n + 2'd1;
								err_d    = 1'b1;
							end
						end else if (mag_w >= LEN_MASK_W || mag_w > CNT_MASK_W
								|| mag_w > mac_w) begin
							rv[n[0]] = mk(K_ERROR, 8'h00, E_OVER_LIMIT);
							n        = n + 2'd1;
							err_d    = 1'b1;
						end else if (mag_w != '0) begin
							args_d = COUNT_BITS'(mag_w);
							mode_d = M_HEADER;
						end
					end else if (nf_done) begin
						if (neg_q && mag_w != '0) begin
							// length of minus one is an empty argument
							if (mag_w == CW'(1)) begin
								arg_done = 1'b1;
							end else begin
								rv[n[0]] = mk(K_ERROR, 8'h00, E_BAD_LENGTH);
								n        = n + 2'd1;
								err_d    = 1'b1;
							end
						end else if (mag_w >= LEN_MASK_W || mag_w > mbl_w) begin
							rv[n[0]] = mk(K_ERROR, 8'h00, E_OVER_LIMIT);
							n        = n + 2'd1;
							err_d    = 1'b1;
						end else begin
							bulk_d = value_q;
							mode_d = (mag_w == '0) ? M_PAY_CR : M_PAYLOAD;
						end
					end
				end
				M_HEADER: begin
					if (data_byte == CH_DOLLAR) begin
						value_d = '0;
						neg_d   = 1'b0;
						phase_d = PH_LEAD;
						ls_d    = 1'b0;
						lcr_d   = 1'b0;
						mode_d  = M_LENGTH;
					end else begin
						rv[n[0]] = mk(K_ERROR, 8'h00, E_NO_HEADER);
						n        = n + 2'd1;
						err_d    = 1'b1;
					end
				end
				M_PAYLOAD: begin
					rv[n[0]] = mk(K_ARG_BYTE, data_byte, E_BAD_COUNT);
					n        = n + 2'd1;
					bulk_d   = bulk_q - LENGTH_BITS'(1);
					if (bulk_d == '0)
						mode_d = M_PAY_CR;
				end
				M_PAY_CR: begin
					if (data_byte == CH_CR) begin
						mode_d = M_PAY_LF;
					end else begin
						rv[n[0]] = mk(K_ERROR, 8'h00, E_BAD_TERM);
						n        = n + 2'd1;
						err_d    = 1'b1;
					end
				end
				M_PAY_LF: begin
					if (data_byte == CH_LF) begin
						arg_done = 1'b1;
					end else begin
						rv[n[0]] = mk(K_ERROR, 8'h00, E_BAD_TERM);
						n        = n + 2'd1;
						err_d    = 1'b1;
					end
				end
				default: do_inline = 1'b1;
			endcase

			if (arg_done) begin
				rv[n[0]] = mk(K_ARG_END, 8'h00, E_BAD_COUNT);
				n        = n + 2'd1;
				args_d   = args_q - COUNT_BITS'(1);
				if (args_d == '0) begin
					rv[n[0]] = mk(K_CMD_END, 8'h00, E_BAD_COUNT);
					n        = n + 2'd1;
					mode_d   = M_START;
				end else begin
					mode_d = M_HEADER;
				end
			end

			if (do_inline) begin
				if (data_byte == CH_LF) begin
					if (tok_d) begin
						rv[n[0]] = mk(K_ARG_END, 8'h00, E_BAD_COUNT);
						n        = n + 2'd1;
					end
					if (lht_d) begin
						rv[n[0]] = mk(K_CMD_END, 8'h00, E_BAD_COUNT);
						n        = n + 2'd1;
					end
					tok_d  = 1'b0;
					lht_d  = 1'b0;
					args_d = '0;
					bulk_d = '0;
					mode_d = M_START;
				end else if (is_space(data_byte)) begin
					if (tok_d) begin
						rv[n[0]] = mk(K_ARG_END, 8'h00, E_BAD_COUNT);
						n        = n + 2'd1;
					end
					tok_d = 1'b0;
				end else begin
					if (!tok_d) begin
						if (CW'(args_d) >= mac_w || CW'(args_d) >= CNT_MASK_W) begin
							err_d = 1'b1;
						end else begin
							args_d = args_d + COUNT_BITS'(1);
							bulk_d = '0;
							tok_d  = 1'b1;
							lht_d  = 1'b1;
						end
					end
					if (!err_d && (CW'(bulk_d) >= mbl_w || CW'(bulk_d) >= LEN_MASK_W))
						err_d = 1'b1;
					if (err_d) begin
						rv[n[0]] = mk(K_ERROR, 8'h00, E_OVER_LIMIT);
						n        = n + 2'd1;
					end else begin
						bulk_d   = bulk_d + LENGTH_BITS'(1);
						rv[n[0]] = mk(K_ARG_BYTE, data_byte, E_BAD_COUNT);
						n        = n + 2'd1;
					end
				end
			end
		end

		if (n == 2'd1)
			rv[0].last = 1'b1;
		else if (n == 2'd2)
			rv[1].last = 1'b1;
	end

	assign push.valid = fire;
	assign push.n     = n;
	assign push.r0    = rv[0];
	assign push.r1    = rv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_START;
			phase_q <= PH_LEAD;
			value_q <= '0;
			bulk_q  <= '0;
			args_q  <= '0;
			neg_q   <= 1'b0;
			tok_q   <= 1'b0;
			lht_q   <= 1'b0;
			err_q   <= 1'b0;
			ls_q    <= 1'b0;
			lcr_q   <= 1'b0;
		end else if (fire) begin
			mode_q  <= mode_d;
			phase_q <= phase_d;
			value_q <= value_d;
			bulk_q  <= bulk_d;
			args_q  <= args_d;
			neg_q   <= neg_d;
			tok_q   <= tok_d;
			lht_q   <= lht_d;
			err_q   <= err_d;
			ls_q    <= ls_d;
			lcr_q   <= lcr_d;
		end
	end

endmodule

>>> hw/rtl/rrp_out_buf.sv
`timescale 1ns / 1ps

module rrp_out_buf import rrp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  push_t      push,
	input  logic       m_tready,
	output logic       m_tvalid,
	output res_t       head,
	output logic [1:0] cnt
);

	res_t       slot_q [2];
	logic [1:0] cnt_q;
	logic       pop;

	assign m_tvalid = (cnt_q != 2'd0);
	assign pop      = m_tvalid && m_tready;
	assign head     = slot_q[0];
	assign cnt      = cnt_q;

	// a push only comes when the buffer is empty or its last entry drains in this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push.valid) begin
			cnt_q <= push.n;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			slot_q[0] <= push.r0;
			slot_q[1] <= push.r1;
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
		end
	end

endmodule

>>> hw/rtl/resp_request_parser_top.sv
// a taken beat waits in the input register, its results go to the output buffer
// throughput: one beat per cycle while m_tready is high and a beat gives at most
// one result; a beat that gives two results holds the input register while the
// two-entry output buffer drains
// reset: arst_n clears the parse state, the buffer and sets the limits to defaults
`timescale 1ns / 1ps
`include "resp_request_parser_top_macros.svh"

module resp_request_parser_top import rrp_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // data_byte
	input  logic [0:0]            s_tuser,   // req_type
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,   // out_byte, error_code, zero fill
	output logic [2:0]            m_tuser,   // kind
	output logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [BULK_REG_W-1:0] cfg_wdata
);

	logic [BULK_REG_W-1:0] max_bulk_length_q;
	logic [CNT_REG_W-1:0]  max_arg_count_q;

	logic       in_valid_s1;
	logic       in_type_s1;
	logic [7:0] in_byte_s1;
	logic       fire;
	logic [1:0] buf_cnt;
	push_t      push;
	res_t       head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bulk_length_q <= MAX_BULK_RESET;
			max_arg_count_q   <= MAX_ARG_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_MAX_BULK: max_bulk_length_q <= cfg_wdata;
				REG_MAX_ARG:  max_arg_count_q   <= cfg_wdata[CNT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// process the held beat once the buffer can take both of its results
	assign fire     = in_valid_s1 && (buf_cnt == 2'd0 || (buf_cnt == 2'd1 && m_tready));
	assign s_tready = !in_valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_type_s1 <= s_tuser[0];
			in_byte_s1 <= s_tdata;
		end
	end

	rrp_parse_core #(
		.LENGTH_BITS(LENGTH_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.req_type       (in_type_s1),
		.data_byte      (in_byte_s1),
		.max_bulk_length(max_bulk_length_q),
		.max_arg_count  (max_arg_count_q),
		.push           (push)
	);

	rrp_out_buf u_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.head    (head),
		.cnt     (buf_cnt)
	);

	assign m_tdata = {5'b0, head.code, head.data};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

	// a held beat that cannot be processed stays put
	`RRP_ASSERT(a_hold_s1, in_valid_s1 && !fire |=> in_valid_s1 && $stable(in_byte_s1))
	// first of a pair of results never closes the beat
	`RRP_NEVER(a_pair_not_last, buf_cnt == 2'd2 && m_tlast)
	// an error is always the final result of its beat
	`RRP_ASSERT(a_err_last, m_tvalid && head.kind == K_ERROR |-> m_tlast)
	// only argument bytes carry data
	`RRP_ASSERT(a_byte_zero, m_tvalid && head.kind != K_ARG_BYTE |-> head.data == 8'h00)

endmodule
